// ===== src/kss_pkg.sv =====
// ----------------------------------------------------------------------------
// kss_pkg
// shared constants, types and the key character table for the keypad sender
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int DEBOUNCE_SAMPLES_DEF = 2;
  localparam int DATA_BITS_DEF        = 8;

  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_BIT  = 1'b1;

  typedef logic [7:0] kss_char_t;

  // indexed [row][column]
  localparam kss_char_t KEY_CHARS [4][4] = '{
    '{8'h46, 8'h45, 8'h44, 8'h43},
    '{8'h42, 8'h41, 8'h39, 8'h38},
    '{8'h37, 8'h36, 8'h35, 8'h34},
    '{8'h33, 8'h32, 8'h31, 8'h30}
  };

  typedef struct packed {
    logic      press;
    kss_char_t code;
    logic [3:0] col_drive;
  } kss_scan_t;

  function automatic kss_char_t key_char(input logic [1:0] row, input logic [1:0] col);
    return KEY_CHARS[row][col];
  endfunction

endpackage

// ===== src/kss_debounce.sv =====
// ----------------------------------------------------------------------------
// kss_debounce
// column scan, per-key sample ring and press edge detection
// ----------------------------------------------------------------------------
module kss_debounce #(
  parameter int DEBOUNCE_SAMPLES = kss_pkg::DEBOUNCE_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              scan_en,
  input  logic [3:0]        rows,
  output kss_pkg::kss_scan_t scan_o
);
  import kss_pkg::*;

  localparam int SLOT_W = (DEBOUNCE_SAMPLES > 1) ? $clog2(DEBOUNCE_SAMPLES) : 1;

  logic [15:0]       samp_r   [DEBOUNCE_SAMPLES];
  logic [15:0]       samp_nxt [DEBOUNCE_SAMPLES];
  logic [15:0]       stable_r, stable_nxt;
  logic [1:0]        col_r, col_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [3:0]        key_hi;
  logic [3:0]        press;
  logic [3:0]        idx [4];
  kss_char_t         code;

  always_comb begin
    samp_nxt   = samp_r;
    stable_nxt = stable_r;
    code       = '0;
    for (int r = 0; r < 4; r++) begin
      idx[r]    = {2'(r), col_r};
      key_hi[r] = rows[r];
      for (int s = 0; s < DEBOUNCE_SAMPLES; s++) begin
        if (SLOT_W'(s) != slot_r) begin
          key_hi[r] = key_hi[r] | samp_r[s][idx[r]];
        end
      end
      press[r] = !key_hi[r] && stable_r[idx[r]];
      samp_nxt[slot_r][idx[r]] = rows[r];
      stable_nxt[idx[r]]       = key_hi[r];
      if (press[r]) begin
        code = key_char(2'(r), col_r);
      end
    end
    col_nxt  = col_r + 2'd1;
    slot_nxt = slot_r;
    if (col_r == 2'd3) begin
      if (slot_r == SLOT_W'(DEBOUNCE_SAMPLES - 1)) begin
        slot_nxt = '0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
  end

  always_comb begin
    scan_o.press     = scan_en && (|press);
    scan_o.code      = code;
    scan_o.col_drive = scan_en ? (4'b0001 << col_nxt) : (4'b0001 << col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DEBOUNCE_SAMPLES; s++) begin
        samp_r[s] <= '1;
      end
      stable_r <= '1;
      col_r    <= '0;
      slot_r   <= '0;
    end else if (scan_en) begin
      samp_r   <= samp_nxt;
      stable_r <= stable_nxt;
      col_r    <= col_nxt;
      slot_r   <= slot_nxt;
    end
  end

endmodule

// ===== src/keypad_scan_serial_sender.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_serial_sender
// 4x4 keypad scanner with debounce that sends each new key as a serial frame
// ----------------------------------------------------------------------------
// channel   dir  tdata                                   tuser
// in_       in   [3:0] row_levels                        [0] kind
// out_      out  [3:0] column_drive, [4] carrier_on,     [0] key_event
//                [12:5] key_code, [13] sending
//
// one transaction in, one transaction out
// a new input is taken every cycle while the output register is empty or drained
// the result register sits between the update logic and out_, so out_ is registered
// rst_n is synchronous: keys released, column 0, no frame, carrier off
// a stall on out_ holds in_tready low until the pending result is taken
// ----------------------------------------------------------------------------
module keypad_scan_serial_sender #(
  parameter int DEBOUNCE_SAMPLES = kss_pkg::DEBOUNCE_SAMPLES_DEF,
  parameter int DATA_BITS        = kss_pkg::DATA_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [3:0] row_levels
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [3:0] column_drive, [4] carrier_on, [12:5] key_code, [13] sending
  output logic        out_tuser   // [0] key_event
);
  import kss_pkg::*;

  localparam int CNT_W = $clog2(DATA_BITS + 1);

  logic             in_acc;
  logic             scan_en;
  logic             bit_en;
  kss_scan_t        scan;

  kss_char_t        byte_r, byte_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             active_r, active_nxt;
  logic             carrier_r, carrier_nxt;

  logic             out_valid_r;
  logic [15:0]      out_data_r, out_data_nxt;
  logic             out_user_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign scan_en   = in_acc && (in_tuser == KIND_SCAN);
  assign bit_en    = in_acc && (in_tuser == KIND_BIT);

  kss_debounce #(
    .DEBOUNCE_SAMPLES(DEBOUNCE_SAMPLES)
  ) u_debounce (
    .clk    (clk),
    .rst_n  (rst_n),
    .scan_en(scan_en),
    .rows   (in_tdata[3:0]),
    .scan_o (scan)
  );

  always_comb begin
    byte_nxt    = byte_r;
    cnt_nxt     = cnt_r;
    active_nxt  = active_r;
    carrier_nxt = carrier_r;
    if (scan.press) begin
      byte_nxt    = scan.code;
      cnt_nxt     = '0;
      active_nxt  = 1'b1;
      carrier_nxt = 1'b1;
    end else if (bit_en && active_r) begin
      if (cnt_r >= CNT_W'(DATA_BITS)) begin
        carrier_nxt = 1'b0;
        active_nxt  = 1'b0;
      end else begin
        carrier_nxt = !byte_r[cnt_r[2:0]];
        cnt_nxt     = cnt_r + CNT_W'(1);
      end
    end
    out_data_nxt = {2'b00, active_nxt, (scan.press ? scan.code : 8'h00),
                    carrier_nxt, scan.col_drive};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r      <= '0;
      cnt_r       <= '0;
      active_r    <= 1'b0;
      carrier_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        byte_r      <= byte_nxt;
        cnt_r       <= cnt_nxt;
        active_r    <= active_nxt;
        carrier_r   <= carrier_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
      out_user_r <= scan.press;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_drive_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot(out_tdata[3:0]))
    else $error("column drive not one-hot");

  a_event_sending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[13] && out_tdata[4]))
    else $error("key event without frame start");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[12:5] == 8'h00))
    else $error("key code set without key event");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> $past(bit_en))
    else $error("frame ended outside a bit tick");

endmodule
